### rtl/fir17_pkg.sv
package fir17_pkg;

	// filter geometry
	localparam int FILTER_ORDER = 16;
	localparam int LINE_LEN     = FILTER_ORDER + 1;
	localparam int ADDR_W       = $clog2(LINE_LEN);
	localparam int TAP_LEN      = 17;

	localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(FILTER_ORDER);

	// item widths
	localparam int SAMPLE_W = 8;
	localparam int ACC_W    = 16;
	localparam int COEF_W   = 8;

	// fixed coefficient set, newest sample meets entry 0
	localparam logic signed [COEF_W-1:0] TAPS [TAP_LEN] = '{
		8'sd0, -8'sd1, 8'sd0, 8'sd6, 8'sd0, -8'sd19, 8'sd0, 8'sd78, 8'sd127,
		8'sd78, 8'sd0, -8'sd19, 8'sd0, 8'sd6, 8'sd0, -8'sd1, 8'sd0
	};

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_LAST,
		ST_DONE
	} fir_state_t;

	// coefficient for one tap, zero past the end of the table
	function automatic logic signed [COEF_W-1:0] tap_coef(input logic [ADDR_W-1:0] k);
		logic signed [COEF_W-1:0] c;
		c = '0;
		for (int i = 0; i < TAP_LEN; i++) begin
			if (int'(k) == i) begin
				c = TAPS[i];
			end
		end
		return c;
	endfunction

endpackage

### rtl/fir17_ram.sv
module fir17_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 17
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/fir17_filter_with_byte_framing_top.sv
// channel   dir  fields (low bit first)
// s_axis    in   tdata: sample[7:0], digital_level[8], zero pad [15:9]
// m_axis    out  tdata: frame_byte0[7:0], frame_byte1[15:8], frame_byte2[23:16]
// cfg       in   cfg_wr_data: filter_enable
//
// filtered item: one tap read and one multiply-accumulate per cycle over the
// 17-entry delay memory, plus fill/drain, before the result is framed.
// bypass item: skips the multiply-accumulate walk. next item is taken once back in idle.
// reset clears the sequencer, write position and per-entry valid bits; an entry
// not yet written reads as zero. a stalled result holds in the output register.
module fir17_filter_with_byte_framing_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // sample[7:0], digital_level[8], zero[15:9]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // frame_byte0[7:0], frame_byte1[15:8], frame_byte2[23:16]
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data
);

	localparam int AW = fir17_pkg::ADDR_W;

	fir17_pkg::fir_state_t state_q, state_d;

	logic                  filt_en_q;
	logic                  mode_q;
	logic [7:0]            sample_q;
	logic                  dflag_q;
	logic [AW-1:0]         wp_q;
	logic [AW-1:0]         wp_next;
	logic [AW-1:0]         rd_addr_q;
	logic [AW-1:0]         tap_q;
	logic [fir17_pkg::LINE_LEN-1:0] vld_q;
	logic                  rd_s1;
	logic                  vld_s1;
	logic [AW-1:0]         tap_s1;
	logic [7:0]            rdata;
	logic signed [7:0]     tap_data;
	logic signed [15:0]    prod;
	logic [fir17_pkg::ACC_W-1:0] acc_q;
	logic                  s_accept;
	logic                  load_out;
	logic                  ram_we;
	logic [7:0]            b0, b1, b2;

	assign s_accept = s_axis_tvalid && s_axis_tready;
	assign ram_we   = s_accept && filt_en_q;
	assign wp_next  = (wp_q == fir17_pkg::LAST_IDX) ? '0 : wp_q + AW'(1);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_en_q <= 1'b1;
		end else if (cfg_wr_en) begin
			filt_en_q <= cfg_wr_data;
		end
	end

	// delay line storage
	fir17_ram #(
		.WIDTH (fir17_pkg::SAMPLE_W),
		.DEPTH (fir17_pkg::LINE_LEN)
	) u_line (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wp_next),
		.wdata (s_axis_tdata[7:0]),
		.raddr (rd_addr_q),
		.rdata (rdata)
	);

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fir17_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and handshakes
	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		load_out      = 1'b0;
		case (state_q)
			fir17_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = filt_en_q ? fir17_pkg::ST_MAC : fir17_pkg::ST_DONE;
				end
			end
			fir17_pkg::ST_MAC: begin
				if (tap_q == fir17_pkg::LAST_IDX) begin
					state_d = fir17_pkg::ST_LAST;
				end
			end
			fir17_pkg::ST_LAST: begin
				state_d = fir17_pkg::ST_DONE;
			end
			fir17_pkg::ST_DONE: begin
				if (!m_axis_tvalid || m_axis_tready) begin
					load_out = 1'b1;
					state_d  = fir17_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fir17_pkg::ST_IDLE;
			end
		endcase
	end

	// control: write position, valid bits, read walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			vld_q     <= '0;
			rd_addr_q <= '0;
			tap_q     <= '0;
			rd_s1     <= 1'b0;
			vld_s1    <= 1'b0;
			tap_s1    <= '0;
		end else begin
			rd_s1 <= (state_q == fir17_pkg::ST_MAC);
			if (ram_we) begin
				wp_q           <= wp_next;
				vld_q[wp_next] <= 1'b1;
				rd_addr_q      <= wp_next;
				tap_q          <= '0;
			end else if (state_q == fir17_pkg::ST_MAC) begin
				rd_addr_q <= (rd_addr_q == '0) ? fir17_pkg::LAST_IDX : rd_addr_q - AW'(1);
				tap_q     <= tap_q + AW'(1);
			end
			vld_s1 <= vld_q[rd_addr_q];
			tap_s1 <= tap_q;
		end
	end

	// item payload latched at accept
	always_ff @(posedge clk) begin
		if (s_accept) begin
			sample_q <= s_axis_tdata[7:0];
			dflag_q  <= !s_axis_tdata[8];
			mode_q   <= filt_en_q;
		end
	end

	// multiply-accumulate, unwritten entries count as zero
	assign tap_data = vld_s1 ? signed'(rdata) : 8'sd0;
	assign prod     = fir17_pkg::tap_coef(tap_s1) * tap_data;

	always_ff @(posedge clk) begin
		if (s_accept) begin
			acc_q <= '0;
		end else if (rd_s1) begin
			acc_q <= acc_q + fir17_pkg::ACC_W'(prod);
		end
	end

	// byte framing
	always_comb begin
		if (mode_q) begin
			b0 = {2'b01, acc_q[15:10]};
			b1 = {1'b1, 1'b0, dflag_q, acc_q[9:5]};
			b2 = {3'b100, acc_q[4:0]};
		end else begin
			b0 = {2'b00, sample_q[7:2]};
			b1 = {1'b1, 1'b0, dflag_q, 3'b000, sample_q[1:0]};
			b2 = 8'h80;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (load_out) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_axis_tdata <= {b2, b1, b0};
		end
	end

	// a filtered sample marks its entry as written
	a_entry_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> vld_q[wp_q])
		else $error("written delay entry not marked valid");

	// the last tap is still in flight when the sequencer drains
	a_last_tap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fir17_pkg::ST_LAST) |-> (rd_s1 && tap_s1 == fir17_pkg::LAST_IDX))
		else $error("drain without the final tap product");

	// a new result appears only from the framing state
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> ($past(state_q) == fir17_pkg::ST_DONE))
		else $error("result raised outside framing state");

endmodule
